[src/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/slpsf_pkg.sv]
`default_nettype none

package slpsf_pkg;

  localparam int GLYPH_COUNT_DEF = 16;
  localparam int GLYPH_BYTES     = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef struct packed {
    logic       go;
    logic [3:0] first;
    logic [3:0] offset;
    logic [1:0] line;
  } emit_req_t;

endpackage

`default_nettype wire

[src/slpsf_glyph_mem.sv]
`default_nettype none

module slpsf_glyph_mem #(
  parameter int Depth = 512,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] addr,
  input  wire logic [7:0]       wdata,
  output logic      [7:0]       rdata
);

  logic [7:0] mem_r [Depth];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/slpsf_scan_seq.sv]
`default_nettype none

`include "assert_macros.svh"

module slpsf_scan_seq
  import slpsf_pkg::*;
#(
  parameter int GlyphCount = GLYPH_COUNT_DEF,
  parameter int AddrW      = $clog2(GlyphCount * GLYPH_BYTES)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire emit_req_t        req,
  input  wire logic [7:0]       port,
  output logic                  rd_en,
  output logic      [AddrW-1:0] rd_addr,
  input  wire logic [7:0]       rd_data,
  output logic                  busy,
  output logic                  out_strobe,
  output logic      [7:0]       out_shift_byte,
  output logic      [7:0]       out_port_select,
  output logic      [1:0]       out_latch_line,
  output logic                  out_last
);

  logic       active_r, active_nxt;
  logic [4:0] step_r, step_nxt;
  logic [3:0] first_r;
  logic [3:0] offset_r;
  logic [1:0] line_r;

  logic       vld_d1_r;
  logic       which_d1_r;
  logic [3:0] idx_d1_r;
  logic       blank_d1_r;
  logic [7:0] hi_byte_r;

  logic       strobe_r;
  logic [7:0] byte_r;
  logic [7:0] port_r;
  logic       last_r;

  logic [3:0]  idx;
  logic        which;
  logic [3:0]  row;
  logic [2:0]  kk;
  logic [4:0]  glyph;
  logic        blank;
  logic [9:0]  addr_full;
  logic [7:0]  lo_byte;
  logic [15:0] pair;

  always_comb begin
    idx       = step_r[4:1];
    which     = step_r[0];
    row       = {~idx[1:0], line_r};
    kk        = {1'b0, idx[3:2]} + {2'b00, offset_r[3]} + {2'b00, which};
    glyph     = {1'b0, first_r} + {3'b000, kk[2:1]};
    blank     = 32'(glyph) >= GlyphCount;
    addr_full = {glyph, row, kk[0]};
    lo_byte   = blank_d1_r ? 8'h00 : rd_data;
    pair      = {hi_byte_r, lo_byte} << offset_r[2:0];
  end

  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    if (active_r) begin
      step_nxt = step_r + 5'd1;
      if (step_r == 5'd31) begin
        active_nxt = 1'b0;
      end
    end else if (req.go) begin
      active_nxt = 1'b1;
      step_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
      vld_d1_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
      vld_d1_r <= active_r;
      strobe_r <= vld_d1_r && which_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!active_r && req.go) begin
      first_r  <= req.first;
      offset_r <= req.offset;
      line_r   <= req.line;
    end
    which_d1_r <= which;
    idx_d1_r   <= idx;
    blank_d1_r <= blank;
    if (vld_d1_r && !which_d1_r) begin
      hi_byte_r <= lo_byte;
    end
    if (vld_d1_r && which_d1_r) begin
      byte_r <= pair[15:8];
      port_r <= port;
      last_r <= idx_d1_r == 4'd15;
    end
  end

  assign rd_en           = active_r;
  assign rd_addr         = AddrW'(addr_full);
  assign busy            = active_r || vld_d1_r;
  assign out_strobe      = strobe_r;
  assign out_shift_byte  = byte_r;
  assign out_port_select = port_r;
  assign out_latch_line  = line_r;
  assign out_last        = strobe_r && last_r;

  `ASSERT_CLK(a_strobe_spaced, out_strobe |=> !out_strobe, "result strobes in adjacent cycles")
  `ASSERT_CLK(a_go_busy, (req.go && !busy) |=> busy, "emit accepted but block not busy")
  `ASSERT_CLK(a_strobe_in_emit, out_strobe |-> $past(vld_d1_r), "result without a read")
  `ASSERT_CLK(a_wrap_ends, (active_r && step_r == 5'd31) |=> !active_r, "read sweep overran")

endmodule

`default_nettype wire

[src/scrolling_led_panel_scan_feeder.sv]
`default_nettype none

// Quarter-scan feeder for a 16x32 scrolling LED panel. A write command (busy stays low) stores
// one glyph byte; an emit command produces 16 shift bytes, one strobe per byte, with last high
// on the sixteenth. An emit keeps busy high until its reads are done, as each shift byte needs
// two reads of the single-port glyph memory.
// The receiver cannot stall, so every strobe must be taken.
// Glyph bytes must be written before an emit reads them.
module scrolling_led_panel_scan_feeder
  import slpsf_pkg::*;
#(
  parameter int GlyphCount = GLYPH_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_command,
  input  wire logic [8:0] in_glyph_address,
  input  wire logic [7:0] in_glyph_byte,
  input  wire logic [3:0] in_first_character,
  input  wire logic [3:0] in_bit_offset,
  input  wire logic [1:0] in_scan_line,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  output logic            out_strobe,
  output logic      [7:0] out_shift_byte,
  output logic      [7:0] out_port_select,
  output logic      [1:0] out_latch_line,
  output logic            out_last
);

  localparam int StoreDepth = GlyphCount * GLYPH_BYTES;
  localparam int AddrW      = $clog2(StoreDepth);

  logic [7:0]       panel_port_r;
  logic             accept;
  logic             wr_en;
  emit_req_t        req;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             mem_en;
  logic [AddrW-1:0] mem_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_port_r <= '0;
    end else if (cfg_we) begin
      panel_port_r <= cfg_wdata;
    end
  end

  always_comb begin
    accept     = start && !busy;
    wr_en      = accept && (in_command == CMD_WRITE) &&
                 (32'(in_glyph_address) < StoreDepth);
    req.go     = accept && (in_command == CMD_EMIT);
    req.first  = in_first_character;
    req.offset = in_bit_offset;
    req.line   = in_scan_line;
    mem_en     = wr_en || rd_en;
    mem_addr   = rd_en ? rd_addr : AddrW'(in_glyph_address);
  end

  slpsf_glyph_mem #(
    .Depth (StoreDepth),
    .AddrW (AddrW)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (wr_en),
    .addr  (mem_addr),
    .wdata (in_glyph_byte),
    .rdata (rd_data)
  );

  slpsf_scan_seq #(
    .GlyphCount (GlyphCount),
    .AddrW      (AddrW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .port            (panel_port_r),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .busy            (busy),
    .out_strobe      (out_strobe),
    .out_shift_byte  (out_shift_byte),
    .out_port_select (out_port_select),
    .out_latch_line  (out_latch_line),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
